// ===== rtl/flight_phase_detector_unit_defines.svh =====
// Assertion macros shared by the flight phase detector checker
`ifndef FLIGHT_PHASE_DETECTOR_UNIT_DEFINES_SVH
`define FLIGHT_PHASE_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FPD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define FPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fpd_pkg.sv =====
// Shared types, constants and helpers of the flight phase detector
package fpd_pkg;

  localparam int SENSOR_W   = 16;
  localparam int CONF_W     = 5;
  localparam int VOTES_W    = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int SCNT_W     = 7;

  localparam int DEF_LIFTOFF_WINDOW = 16;
  localparam int DEF_BURNOUT_WINDOW = 16;

  // axis picking stops once the sample counter reaches this value
  localparam logic [SCNT_W-1:0] AXIS_PICK_LIMIT = 7'd100;

  // reset values of the configuration registers
  localparam logic signed [SENSOR_W-1:0] RST_LIFT_THR     = 16'sd2000;
  localparam logic signed [SENSOR_W-1:0] RST_BURN_THR     = 16'sd0;
  localparam logic [CONF_W-1:0]          RST_LIFTOFF_CONF = 5'd12;
  localparam logic [CONF_W-1:0]          RST_BURNOUT_CONF = 5'd12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIFT_THR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURN_THR     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFTOFF_CONF = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BURNOUT_CONF = 8'd3;

  typedef enum logic [2:0] {
    STAGE_PAD      = 3'd0,
    STAGE_POWERED  = 3'd1,
    STAGE_COASTING = 3'd2,
    STAGE_DROGUE   = 3'd3,
    STAGE_MAIN     = 3'd4,
    STAGE_LANDED   = 3'd5
  } stage_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic signed [SENSOR_W-1:0] accel_x;
    logic signed [SENSOR_W-1:0] accel_y;
    logic signed [SENSOR_W-1:0] accel_z;
    logic signed [SENSOR_W-1:0] grav_x;
    logic signed [SENSOR_W-1:0] grav_y;
    logic signed [SENSOR_W-1:0] grav_z;
    logic                       drogue_ready;
    logic                       main_ready;
  } sample_t;

  typedef struct packed {
    stage_t               stage;
    logic [VOTES_W-1:0]   liftoff_votes;
    logic [VOTES_W-1:0]   burnout_votes;
    axis_t                vertical_axis;
  } result_t;

  // status of one vote window toward the stage logic
  typedef struct packed {
    logic               hit;
    logic [VOTES_W-1:0] votes;
  } vote_stat_t;

  // magnitude of a signed sensor value, one bit wider
  function automatic logic [SENSOR_W:0] mag(input logic signed [SENSOR_W-1:0] v);
    logic signed [SENSOR_W:0] ext;
    ext = {v[SENSOR_W-1], v};
    return v[SENSOR_W-1] ? (SENSOR_W+1)'(-ext) : (SENSOR_W+1)'(ext);
  endfunction

endpackage

// ===== rtl/fpd_if.sv =====
// Valid/ready channels of the flight phase detector: samples, results, config writes
interface fpd_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpd_pkg::SENSOR_W-1:0] accel_x;
  logic signed [fpd_pkg::SENSOR_W-1:0] accel_y;
  logic signed [fpd_pkg::SENSOR_W-1:0] accel_z;
  logic signed [fpd_pkg::SENSOR_W-1:0] grav_x;
  logic signed [fpd_pkg::SENSOR_W-1:0] grav_y;
  logic signed [fpd_pkg::SENSOR_W-1:0] grav_z;
  logic                                drogue_ready;
  logic                                main_ready;

  modport source (output valid, accel_x, accel_y, accel_z, grav_x, grav_y, grav_z,
                  drogue_ready, main_ready, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, grav_x, grav_y, grav_z,
                  drogue_ready, main_ready, output ready);
endinterface

interface fpd_result_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       stage;
  logic [fpd_pkg::VOTES_W-1:0]      liftoff_votes;
  logic [fpd_pkg::VOTES_W-1:0]      burnout_votes;
  logic [1:0]                       vertical_axis;

  modport source (output valid, stage, liftoff_votes, burnout_votes, vertical_axis,
                  input ready);
  modport sink   (input valid, stage, liftoff_votes, burnout_votes, vertical_axis,
                  output ready);
endinterface

interface fpd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fpd_pkg::CFG_IDX_W-1:0]     index;
  logic [fpd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/flight_phase_detector_unit.sv =====
// Top level of the flight phase detector
//
// Channels: sample (sink) takes one sensor word per accepted valid/ready
// handshake; result (source) gives one word per sample with the flight stage,
// both vote counts and the chosen vertical axis; cfg (sink) writes the four
// threshold and confidence registers and is always ready; the user must write
// them only while the block idles, which the block itself does not enforce.
// Path: an accepted sample goes to the input register, then the result register.
// Throughput: one sample per cycle while result is taken; the input register
// refills in the same cycle its word moves to the result register, so the rate
// is set by the single-pass update of stage, windows and counters.
// Stall: while result is held, the result register keeps its word and one
// further sample waits in the input register; sample.ready then drops.
// Reset (rst, synchronous): stage standby, axis x, windows and counts clear,
// sample counter one, registers back to defaults, both channels empty.
module flight_phase_detector_unit #(
  parameter int LIFTOFF_WINDOW = fpd_pkg::DEF_LIFTOFF_WINDOW,
  parameter int BURNOUT_WINDOW = fpd_pkg::DEF_BURNOUT_WINDOW
) (
  input logic          clk,
  input logic          rst,
  fpd_sample_if.sink   sample,
  fpd_result_if.source result,
  fpd_cfg_if.sink      cfg
);

  // configuration registers
  logic signed [fpd_pkg::SENSOR_W-1:0] lift_thr;
  logic signed [fpd_pkg::SENSOR_W-1:0] burn_thr;
  logic [fpd_pkg::CONF_W-1:0]          lift_conf;
  logic [fpd_pkg::CONF_W-1:0]          burn_conf;

  // input and result registers
  logic              in_valid;
  fpd_pkg::sample_t  in_word;
  logic              res_valid;
  fpd_pkg::result_t  res_word;
  logic              advance;

  // flight state
  fpd_pkg::stage_t              stage;
  fpd_pkg::stage_t              stage_next;
  fpd_pkg::axis_t               axis;
  fpd_pkg::axis_t               axis_next;
  logic [fpd_pkg::SCNT_W-1:0]   sample_count;
  logic                         picking;
  logic signed [fpd_pkg::SENSOR_W-1:0] vert;
  logic                         lo_vote;
  logic                         bo_vote;
  fpd_pkg::vote_stat_t          lo_stat;
  fpd_pkg::vote_stat_t          bo_stat;

  // config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lift_thr  <= fpd_pkg::RST_LIFT_THR;
      burn_thr  <= fpd_pkg::RST_BURN_THR;
      lift_conf <= fpd_pkg::RST_LIFTOFF_CONF;
      burn_conf <= fpd_pkg::RST_BURNOUT_CONF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fpd_pkg::REG_LIFT_THR:     lift_thr  <= $signed(cfg.data);
        fpd_pkg::REG_BURN_THR:     burn_thr  <= $signed(cfg.data);
        fpd_pkg::REG_LIFTOFF_CONF: lift_conf <= cfg.data[fpd_pkg::CONF_W-1:0];
        fpd_pkg::REG_BURNOUT_CONF: burn_conf <= cfg.data[fpd_pkg::CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input word moves on when the result slot is free or draining
  assign advance      = in_valid && (!res_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_word.accel_x      <= sample.accel_x;
      in_word.accel_y      <= sample.accel_y;
      in_word.accel_z      <= sample.accel_z;
      in_word.grav_x       <= sample.grav_x;
      in_word.grav_y       <= sample.grav_y;
      in_word.grav_z       <= sample.grav_z;
      in_word.drogue_ready <= sample.drogue_ready;
      in_word.main_ready   <= sample.main_ready;
    end
  end

  // vertical axis: largest gravity magnitude, ties go to the lower axis
  assign picking = sample_count < fpd_pkg::AXIS_PICK_LIMIT;

  always_comb begin
    logic [fpd_pkg::SENSOR_W:0] gx;
    logic [fpd_pkg::SENSOR_W:0] gy;
    logic [fpd_pkg::SENSOR_W:0] gz;
    logic [fpd_pkg::SENSOR_W:0] best;
    gx = fpd_pkg::mag(in_word.grav_x);
    gy = fpd_pkg::mag(in_word.grav_y);
    gz = fpd_pkg::mag(in_word.grav_z);
    best = gx;
    axis_next = axis;
    if (picking) begin
      axis_next = fpd_pkg::AXIS_X;
      if (gy > best) begin
        axis_next = fpd_pkg::AXIS_Y;
        best      = gy;
      end
      if (gz > best) begin
        axis_next = fpd_pkg::AXIS_Z;
      end
    end
  end

  always_comb begin
    unique case (axis_next)
      fpd_pkg::AXIS_Y: vert = in_word.accel_y;
      fpd_pkg::AXIS_Z: vert = in_word.accel_z;
      default:         vert = in_word.accel_x;
    endcase
  end

  assign lo_vote = vert > lift_thr;
  assign bo_vote = vert < burn_thr;

  // liftoff and burnout vote windows
  fpd_vote_window #(.WINDOW(LIFTOFF_WINDOW)) u_liftoff (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .active (stage == fpd_pkg::STAGE_PAD),
    .vote   (lo_vote),
    .conf   (lift_conf),
    .stat   (lo_stat)
  );

  fpd_vote_window #(.WINDOW(BURNOUT_WINDOW)) u_burnout (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .active (stage == fpd_pkg::STAGE_POWERED),
    .vote   (bo_vote),
    .conf   (burn_conf),
    .stat   (bo_stat)
  );

  // stage sequencer: at most one step per sample
  always_comb begin
    stage_next = stage;
    unique case (stage)
      fpd_pkg::STAGE_PAD:      if (lo_stat.hit) stage_next = fpd_pkg::STAGE_POWERED;
      fpd_pkg::STAGE_POWERED:  if (bo_stat.hit) stage_next = fpd_pkg::STAGE_COASTING;
      fpd_pkg::STAGE_COASTING: if (in_word.drogue_ready) stage_next = fpd_pkg::STAGE_DROGUE;
      fpd_pkg::STAGE_DROGUE:   if (in_word.main_ready) stage_next = fpd_pkg::STAGE_MAIN;
      fpd_pkg::STAGE_MAIN:     stage_next = fpd_pkg::STAGE_LANDED;
      fpd_pkg::STAGE_LANDED:   stage_next = fpd_pkg::STAGE_LANDED;
      default:                 stage_next = stage;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= fpd_pkg::STAGE_PAD;
      axis         <= fpd_pkg::AXIS_X;
      sample_count <= fpd_pkg::SCNT_W'(1);
    end else if (advance) begin
      stage <= stage_next;
      axis  <= axis_next;
      if (picking) begin
        sample_count <= sample_count + fpd_pkg::SCNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word.stage         <= stage_next;
      res_word.liftoff_votes <= lo_stat.votes;
      res_word.burnout_votes <= bo_stat.votes;
      res_word.vertical_axis <= axis_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.stage         = res_word.stage;
  assign result.liftoff_votes = res_word.liftoff_votes;
  assign result.burnout_votes = res_word.burnout_votes;
  assign result.vertical_axis = res_word.vertical_axis;

endmodule

// ===== rtl/fpd_vote_window.sv =====
// Sliding vote window: rotating bit line plus running vote count
module fpd_vote_window #(
  parameter int WINDOW = fpd_pkg::DEF_LIFTOFF_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,    // one word processed this cycle
  input  logic                          active,  // window belongs to the current stage
  input  logic                          vote,
  input  logic [fpd_pkg::CONF_W-1:0]    conf,
  output fpd_pkg::vote_stat_t           stat
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int XW = (CW > fpd_pkg::VOTES_W) ? CW : fpd_pkg::VOTES_W;

  // bit WINDOW-1 is the slot being revisited this sample
  logic [WINDOW-1:0] win;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [XW-1:0]     count_ext;
  logic [XW-1:0]     shown_ext;
  logic              drop;

  assign drop       = win[WINDOW-1];
  assign count_next = count - CW'(drop) + CW'(vote);
  assign count_ext  = XW'(count_next);
  assign shown_ext  = active ? count_ext : XW'(count);

  // confidence check on the updated count
  assign stat.hit   = count_ext >= XW'(conf);
  // vote output saturates at the field's top value
  assign stat.votes = (shown_ext > XW'(31)) ? fpd_pkg::VOTES_W'(31)
                                            : shown_ext[fpd_pkg::VOTES_W-1:0];

  // the line turns once per sample; an idle stage puts the old bit back
  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= '0;
      count <= '0;
    end else if (step) begin
      if (active) begin
        win   <= (win << 1) | WINDOW'(vote);
        count <= count_next;
      end else begin
        win   <= (win << 1) | WINDOW'(drop);
      end
    end
  end

endmodule

// ===== rtl/fpd_checker.sv =====
// Port-level checker of the flight phase detector and its bind
`include "flight_phase_detector_unit_defines.svh"

module fpd_checker #(
  parameter int LIFTOFF_WINDOW = fpd_pkg::DEF_LIFTOFF_WINDOW,
  parameter int BURNOUT_WINDOW = fpd_pkg::DEF_BURNOUT_WINDOW
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [2:0]                  res_stage,
  input logic [fpd_pkg::VOTES_W-1:0] res_liftoff_votes,
  input logic [fpd_pkg::VOTES_W-1:0] res_burnout_votes
);

  localparam logic [fpd_pkg::VOTES_W-1:0] LO_MAX =
    fpd_pkg::VOTES_W'((LIFTOFF_WINDOW > 31) ? 31 : LIFTOFF_WINDOW);
  localparam logic [fpd_pkg::VOTES_W-1:0] BO_MAX =
    fpd_pkg::VOTES_W'((BURNOUT_WINDOW > 31) ? 31 : BURNOUT_WINDOW);

  // a held result word does not change
  `FPD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_stage) && $stable(res_liftoff_votes), "result word changed while stalled")

  // no result right after reset
  `FPD_ASSERT_IMPL(a_res_reset, clk, rst, $past(rst), !res_valid, "result valid right after reset")

  // landed is final
  `FPD_ASSERT_NEXT(a_landed_sticky, clk, rst, res_valid && res_ready && res_stage == fpd_pkg::STAGE_LANDED, !res_valid || res_stage == fpd_pkg::STAGE_LANDED, "stage left landed")

  // counts never exceed their windows; burnout votes only start after liftoff
  `FPD_ASSERT_IMPL(a_votes_bound, clk, rst, res_valid, res_liftoff_votes <= LO_MAX && res_burnout_votes <= BO_MAX, "vote count above window")

  `FPD_ASSERT_IMPL(a_pad_no_burnout, clk, rst, res_valid && res_stage == fpd_pkg::STAGE_PAD, res_burnout_votes == '0, "burnout votes in standby")

endmodule

bind flight_phase_detector_unit fpd_checker #(
  .LIFTOFF_WINDOW (LIFTOFF_WINDOW),
  .BURNOUT_WINDOW (BURNOUT_WINDOW)
) u_fpd_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_stage         (result.stage),
  .res_liftoff_votes (result.liftoff_votes),
  .res_burnout_votes (result.burnout_votes)
);

// ===== bench/fpd_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard of the flight phase detector bench: stage tracker and result checks
package fpd_tb_pkg;
  import fpd_pkg::*;

  class flight_scoreboard;
    // register copies
    int lo_thr;
    int bo_thr;
    int lo_conf;
    int bo_conf;
    // tracked flight state
    stage_t stage;
    axis_t  axis;
    int     sample_num;
    int     lo_slot;
    int     bo_slot;
    int     lo_votes;
    int     bo_votes;
    bit     lo_win[DEF_LIFTOFF_WINDOW];
    bit     bo_win[DEF_BURNOUT_WINDOW];
    // words still owed by the block, oldest first
    result_t expected_reports[$];
    int      fails;
    int      checked;

    function new();
      lo_thr     = RST_LIFT_THR;
      bo_thr     = RST_BURN_THR;
      lo_conf    = RST_LIFTOFF_CONF;
      bo_conf    = RST_BURNOUT_CONF;
      stage      = STAGE_PAD;
      axis       = AXIS_X;
      sample_num = 1;
      lo_slot    = 1 % DEF_LIFTOFF_WINDOW;
      bo_slot    = 1 % DEF_BURNOUT_WINDOW;
      lo_votes   = 0;
      bo_votes   = 0;
      fails      = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LIFT_THR:     lo_thr = $signed(data[SENSOR_W-1:0]);
        REG_BURN_THR:     bo_thr = $signed(data[SENSOR_W-1:0]);
        REG_LIFTOFF_CONF: lo_conf = data[CONF_W-1:0];
        REG_BURNOUT_CONF: bo_conf = data[CONF_W-1:0];
        default: ;
      endcase
    endfunction

    function int magnitude(logic signed [SENSOR_W-1:0] v);
      int x;
      x = v;
      return (x < 0) ? -x : x;
    endfunction

    // advance the flight state by one accepted sample word, queue its result
    function void note_sample(sample_t s);
      int      g[3];
      int      a[3];
      int      vert;
      result_t r;
      if (sample_num < int'(AXIS_PICK_LIMIT)) begin
        g[0] = magnitude(s.grav_x);
        g[1] = magnitude(s.grav_y);
        g[2] = magnitude(s.grav_z);
        // ties keep the lower axis
        axis = AXIS_X;
        if (g[1] > g[0]) axis = AXIS_Y;
        if (g[2] > g[int'(axis)]) axis = AXIS_Z;
      end
      a[0] = $signed(s.accel_x);
      a[1] = $signed(s.accel_y);
      a[2] = $signed(s.accel_z);
      vert = a[int'(axis)];

      case (stage)
        STAGE_PAD: begin
          if (lo_win[lo_slot]) lo_votes--;
          lo_win[lo_slot] = (vert > lo_thr);
          if (lo_win[lo_slot]) lo_votes++;
          if (lo_votes >= lo_conf) stage = STAGE_POWERED;
        end
        STAGE_POWERED: begin
          if (bo_win[bo_slot]) bo_votes--;
          bo_win[bo_slot] = (vert < bo_thr);
          if (bo_win[bo_slot]) bo_votes++;
          if (bo_votes >= bo_conf) stage = STAGE_COASTING;
        end
        STAGE_COASTING: if (s.drogue_ready) stage = STAGE_DROGUE;
        STAGE_DROGUE:   if (s.main_ready) stage = STAGE_MAIN;
        STAGE_MAIN:     stage = STAGE_LANDED;
        default: ;
      endcase

      // slots move on every sample, whatever the stage
      lo_slot = (lo_slot + 1) % DEF_LIFTOFF_WINDOW;
      bo_slot = (bo_slot + 1) % DEF_BURNOUT_WINDOW;
      if (sample_num < int'(AXIS_PICK_LIMIT)) sample_num++;

      r.stage         = stage;
      r.liftoff_votes = (lo_votes > 31) ? 5'd31 : VOTES_W'(lo_votes);
      r.burnout_votes = (bo_votes > 31) ? 5'd31 : VOTES_W'(bo_votes);
      r.vertical_axis = axis;
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        fails++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        fails++;
        $display("%0t: result word with no sample pending: expected none, actual %p",
                 $time, got);
        return;
      end
      want = expected_reports.pop_front();
      checked++;
      compare_field("stage", want.stage, got.stage);
      compare_field("liftoff_votes", want.liftoff_votes, got.liftoff_votes);
      compare_field("burnout_votes", want.burnout_votes, got.burnout_votes);
      compare_field("vertical_axis", want.vertical_axis, got.vertical_axis);
    endfunction
  endclass

endpackage

// ===== bench/tb_flight_phase_detector_unit.sv =====
`timescale 1ns / 100ps
// Top of the flight phase detector bench: clock, reset, drivers, monitor and flight plan
module tb_flight_phase_detector_unit;
  import fpd_pkg::*;
  import fpd_tb_pkg::*;

  localparam int MAX_CYCLES = 100000;

  typedef enum {GEN_NOISE, GEN_QUIET, GEN_BOOST} sample_kind_t;
  typedef enum {RX_OPEN, RX_COIN, RX_STALLS} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpd_sample_if sample();
  fpd_result_if result();
  fpd_cfg_if    cfg();

  flight_phase_detector_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  flight_scoreboard sb;
  int       cycles = 0;
  int       burst_left = 0;
  int       rx_left = 0;
  int       rx_hold = 0;
  bit       rx_stalled = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("%0t: run limit of %0d cycles reached", $time, MAX_CYCLES);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && result.valid && result.ready) begin
      got.stage         = stage_t'(result.stage);
      got.liftoff_votes = result.liftoff_votes;
      got.burnout_votes = result.burnout_votes;
      got.vertical_axis = axis_t'(result.vertical_axis);
      sb.check_result(got);
    end
  end

  // receiver back-pressure: open stretches, coin flips, long stalls
  always @(negedge clk) begin : rx_pattern
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(10, 60);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: rdy = 1'b1;
      RX_COIN: rdy = 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold == 0) begin
          rx_stalled = !rx_stalled;
          rx_hold = rx_stalled ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end
        rx_hold--;
        rdy = !rx_stalled;
      end
    endcase
    result.ready <= rdy;
  end

  function automatic sample_t make_sample(sample_kind_t kind, int flag_pct);
    sample_t s;
    s.accel_x = 16'($urandom());
    s.accel_y = 16'($urandom());
    s.accel_z = 16'($urandom());
    s.grav_x  = 16'($urandom());
    s.grav_y  = 16'($urandom());
    s.grav_z  = 16'($urandom());
    case (kind)
      // pad noise, mostly under the liftoff threshold
      GEN_QUIET: begin
        s.accel_x = 16'(int'($urandom_range(0, 2000)) - 500);
        s.accel_y = 16'(int'($urandom_range(0, 2000)) - 500);
        s.accel_z = 16'(int'($urandom_range(0, 2000)) - 500);
      end
      // motor burn on every axis, with the odd glitch word left random
      GEN_BOOST: begin
        if ($urandom_range(0, 19) != 0) begin
          s.accel_x = 16'($urandom_range(4000, 32767));
          s.accel_y = 16'($urandom_range(4000, 32767));
          s.accel_z = 16'($urandom_range(4000, 32767));
        end
      end
      default: ;
    endcase
    s.drogue_ready = ($urandom_range(0, 99) < flag_pct);
    s.main_ready   = ($urandom_range(0, 99) < flag_pct);
    return s;
  endfunction

  // one sample word through the handshake; sender may idle between bursts
  task automatic send_sample(sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        sample.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    sample.accel_x      <= s.accel_x;
    sample.accel_y      <= s.accel_y;
    sample.accel_z      <= s.accel_z;
    sample.grav_x       <= s.grav_x;
    sample.grav_y       <= s.grav_y;
    sample.grav_z       <= s.grav_z;
    sample.drogue_ready <= s.drogue_ready;
    sample.main_ready   <= s.main_ready;
    sample.valid        <= 1'b1;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    sb.note_sample(s);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_fixed(int ax, int ay, int az, int gx, int gy, int gz, bit d, bit m);
    sample_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.grav_x  = 16'(gx);
    s.grav_y  = 16'(gy);
    s.grav_z  = 16'(gz);
    s.drogue_ready = d;
    s.main_ready   = m;
    send_sample(s);
  endtask

  task automatic run_items(sample_kind_t kind, int n, int flag_pct);
    repeat (n) send_sample(make_sample(kind, flag_pct));
  endtask

  // keep sending until the tracked stage moves on, with a cap
  task automatic run_until_leaves(stage_t st, sample_kind_t kind, int flag_pct, int cap);
    int n;
    n = 0;
    while (sb.stage == st && n < cap) begin
      send_sample(make_sample(kind, flag_pct));
      n++;
    end
  endtask

  // sender holds off until every owed result word is back
  task automatic pause_until_drained();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic reconfigure(int lo_thr, int bo_thr, int lo_conf, int bo_conf);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    pause_until_drained();
    idx = '{REG_LIFT_THR, REG_BURN_THR, REG_LIFTOFF_CONF, REG_BURNOUT_CONF};
    val = '{CFG_DATA_W'(lo_thr), CFG_DATA_W'(bo_thr), CFG_DATA_W'(lo_conf),
            CFG_DATA_W'(bo_conf)};
    for (int i = 0; i < 4; i++) begin
      cfg.index <= idx[i];
      cfg.data  <= val[i];
      cfg.valid <= 1'b1;
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      sb.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg.valid <= 1'b0;
  endtask

  function automatic int rand_thr(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  initial begin
    sb = new();
    sample.valid        = 1'b0;
    sample.accel_x      = '0;
    sample.accel_y      = '0;
    sample.accel_z      = '0;
    sample.grav_x       = '0;
    sample.grav_y       = '0;
    sample.grav_z       = '0;
    sample.drogue_ready = 1'b0;
    sample.main_ready   = 1'b0;
    result.ready        = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = REG_LIFT_THR;
    cfg.data            = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults: axis ties, threshold edges, field extremes, stray flags
    send_fixed(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    send_fixed(32767, 0, 0, -32768, -32768, -32768, 1'b1, 1'b1);
    send_fixed(-32768, -32768, -32768, 100, -100, 50, 1'b0, 1'b1);
    send_fixed(0, 2001, 0, 5, -32768, 32767, 1'b1, 1'b0);
    send_fixed(0, 2000, 0, 0, 32767, -32767, 1'b0, 1'b0);
    send_fixed(0, 0, 32767, 1, 2, -32768, 1'b0, 1'b0);
    send_fixed(-1, -1, -1, -32767, 0, 32767, 1'b1, 1'b1);
    send_fixed(2001, 32767, -32768, 1, 0, 0, 1'b0, 1'b0);
    send_fixed(12345, -12345, 0, 0, 0, -1, 1'b0, 1'b0);
    send_fixed(0, 0, 0, 0, -1, 1, 1'b1, 1'b0);

    // standby, confidence out of reach: window churn, axis pick runs out
    reconfigure(rand_thr(-1000, 1000), -32768, 31, 16);
    run_items(GEN_NOISE, 140, 50);
    // nearly every sample votes: count fills the window
    reconfigure(-32768, -32768, 17, 16);
    run_items(GEN_NOISE, 40, 50);
    // no sample can vote: count drains
    reconfigure(32767, -32768, 16, 16);
    run_items(GEN_NOISE, 30, 50);
    // pad quiet, then motor burn until liftoff
    reconfigure(rand_thr(1500, 3000), -32768, 16, 16);
    run_items(GEN_QUIET, 20, 10);
    run_until_leaves(STAGE_PAD, GEN_BOOST, 10, 300);

    // powered: burnout window filled, then partial, then confidence zero
    reconfigure(rand_thr(-3000, 3000), 32767, $urandom_range(1, 16), 31);
    run_items(GEN_NOISE, 60, 50);
    reconfigure(rand_thr(-3000, 3000), rand_thr(-3000, 0), 12, 16'hFFF1);
    run_items(GEN_NOISE, 40, 50);
    reconfigure(rand_thr(-3000, 3000), rand_thr(-3000, 0), 12, 0);
    run_until_leaves(STAGE_POWERED, GEN_NOISE, 50, 10);

    // chute flags are rare, so each stage lasts a while
    run_until_leaves(STAGE_COASTING, GEN_NOISE, 3, 150);
    run_until_leaves(STAGE_DROGUE, GEN_NOISE, 3, 150);
    run_items(GEN_NOISE, 1, 50);

    // landed: registers and flags no longer matter
    reconfigure(rand_thr(-32768, 32767), rand_thr(-32768, 32767),
                $urandom_range(0, 31), $urandom_range(0, 31));
    run_items(GEN_NOISE, 60, 50);

    pause_until_drained();
    repeat (4) @(posedge clk);

    $display("Covered one full flight, standby to landed, with %0d sample words checked;",
             sb.checked);
    $display("final stage %s, %0d mismatches", sb.stage.name(), sb.fails);
    if (sb.fails == 0 && sb.expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_if.sv
rtl/fpd_vote_window.sv
rtl/flight_phase_detector_unit.sv
rtl/fpd_checker.sv
bench/fpd_tb_pkg.sv
bench/tb_flight_phase_detector_unit.sv
